### rtl/core/two_level_lru_cache_model_defines.svh
// assertion macros for the two-level lru cache model
// used by the top level only, no other dependencies
`ifndef TWO_LEVEL_LRU_CACHE_MODEL_DEFINES_SVH
`define TWO_LEVEL_LRU_CACHE_MODEL_DEFINES_SVH
`ifndef SYNTH
`define TLLC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tllc assertion failed");
`define TLLC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tllc assertion failed");
`else
`define TLLC_ASSERT_IMP(lbl, a, c)
`define TLLC_ASSERT_NXT(lbl, a, c)
`endif
`endif

### rtl/core/tllc_pkg.sv
// shared types and constants of the two-level lru cache model
// no dependencies
`timescale 1ns / 1ps
package tllc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int CYC_W      = 11;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_LATENCY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L2_LATENCY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_LATENCY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOC  = 3'd4;

  localparam logic [3:0] RST_BLOCK_OFFSET = 4'd4;
  localparam logic [7:0] RST_L1_LATENCY   = 8'd1;
  localparam logic [7:0] RST_L2_LATENCY   = 8'd5;
  localparam logic [9:0] RST_MEM_LATENCY  = 10'd100;
  localparam logic       RST_WRITE_ALLOC  = 1'b1;

  localparam logic [1:0] LEVEL_L1  = 2'd0;
  localparam logic [1:0] LEVEL_L2  = 2'd1;
  localparam logic [1:0] LEVEL_MEM = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_MAIN, ST_LOOKUP, ST_RD_INV, ST_INV,
    ST_RD_NFILL, ST_NFILL, ST_RD_TOUCH, ST_TOUCH, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_MAIN, RD_INV, RD_NFILL, RD_TOUCH
  } rd_src_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOOKUP, OP_INV, OP_NFILL, OP_TOUCH
  } op_t;

  typedef struct packed {
    logic    clr;
    logic    accept;
    rd_src_t rd_src;
    op_t     op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic near_hit;
    logic far_hit;
    logic far_ev;
    logic near_evd;
    logic is_write;
    logic walloc;
  } status_t;

endpackage

### rtl/core/tllc_dp.sv
// datapath of the two-level lru cache model: config, tag and lru memories, result
// depends on tllc_pkg
`timescale 1ns / 1ps
module tllc_dp #(
  parameter int NEAR_SETS_LOG2 = 6,
  parameter int NEAR_WAYS_LOG2 = 2,
  parameter int FAR_SETS_LOG2  = 8,
  parameter int FAR_WAYS_LOG2  = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tllc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tllc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_action,
  input  logic [31:0]                    in_byte_address,
  input  tllc_pkg::cmd_t                 cmd,
  output tllc_pkg::status_t              status,
  output logic [1:0]                     out_hit_level,
  output logic [tllc_pkg::CYC_W-1:0]     out_access_cycles
);

  localparam int NWAYS = 1 << NEAR_WAYS_LOG2;
  localparam int FWAYS = 1 << FAR_WAYS_LOG2;
  localparam int NAW   = (NEAR_WAYS_LOG2 > 0) ? NEAR_WAYS_LOG2 : 1;
  localparam int FAW   = (FAR_WAYS_LOG2 > 0) ? FAR_WAYS_LOG2 : 1;
  localparam int NSETS = 1 << NEAR_SETS_LOG2;
  localparam int FSETS = 1 << FAR_SETS_LOG2;
  localparam int NSW   = (NEAR_SETS_LOG2 > 0) ? NEAR_SETS_LOG2 : 1;
  localparam int FSW   = (FAR_SETS_LOG2 > 0) ? FAR_SETS_LOG2 : 1;
  localparam int CLR_ROWS = (NSETS > FSETS) ? NSETS : FSETS;
  localparam int CLR_W = ((NEAR_SETS_LOG2 > FAR_SETS_LOG2) ? NEAR_SETS_LOG2 : FAR_SETS_LOG2) + 1;

  typedef logic [NWAYS-1:0][NAW-1:0] nage_row_t;
  typedef logic [FWAYS-1:0][FAW-1:0] fage_row_t;
  typedef logic [NWAYS-1:0][31:0]    ntag_row_t;
  typedef logic [FWAYS-1:0][31:0]    ftag_row_t;

  // configuration
  logic [3:0] bob_r;
  logic [7:0] l1_lat_r, l2_lat_r;
  logic [9:0] mem_lat_r;
  logic       walloc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bob_r     <= tllc_pkg::RST_BLOCK_OFFSET;
      l1_lat_r  <= tllc_pkg::RST_L1_LATENCY;
      l2_lat_r  <= tllc_pkg::RST_L2_LATENCY;
      mem_lat_r <= tllc_pkg::RST_MEM_LATENCY;
      walloc_r  <= tllc_pkg::RST_WRITE_ALLOC;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tllc_pkg::REG_BLOCK_OFFSET: bob_r     <= cfg_wdata[3:0];
        tllc_pkg::REG_L1_LATENCY:   l1_lat_r  <= cfg_wdata[7:0];
        tllc_pkg::REG_L2_LATENCY:   l2_lat_r  <= cfg_wdata[7:0];
        tllc_pkg::REG_MEM_LATENCY:  mem_lat_r <= cfg_wdata[9:0];
        tllc_pkg::REG_WRITE_ALLOC:  walloc_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [31:0] addr_r, eaddr_r, eaddr_nxt;
  logic        wr_r, eaddr_ld;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= in_byte_address;
      wr_r   <= in_action;
    end
    if (eaddr_ld) eaddr_r <= eaddr_nxt;
  end

  // address split
  logic [5:0] nsh, fsh;
  assign nsh = 6'(bob_r) + 6'(NEAR_SETS_LOG2);
  assign fsh = 6'(bob_r) + 6'(FAR_SETS_LOG2);

  function automatic logic [NSW-1:0] nset_of(input logic [31:0] a, input logic [3:0] b);
    nset_of = NSW'((a >> b) & 32'(NSETS - 1));
  endfunction

  function automatic logic [FSW-1:0] fset_of(input logic [31:0] a, input logic [3:0] b);
    fset_of = FSW'((a >> b) & 32'(FSETS - 1));
  endfunction

  // clearing pass
  logic [CLR_W-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  nage_row_t nage_init;
  fage_row_t fage_init;
  always_comb begin
    for (int w = 0; w < NWAYS; w++) nage_init[w] = NAW'(w);
    for (int w = 0; w < FWAYS; w++) fage_init[w] = FAW'(w);
  end

  // memories
  logic [NWAYS-1:0] nval_mem [NSETS];
  logic [NWAYS-1:0] ndty_mem [NSETS];
  nage_row_t        nage_mem [NSETS];
  ntag_row_t        ntag_mem [NSETS];
  logic [FWAYS-1:0] fval_mem [FSETS];
  fage_row_t        fage_mem [FSETS];
  ftag_row_t        ftag_mem [FSETS];

  logic [NWAYS-1:0] nval_q, ndty_q, nval_w, ndty_w;
  nage_row_t        nage_q, nage_w;
  ntag_row_t        ntag_q, ntag_w;
  logic [FWAYS-1:0] fval_q, fval_w;
  fage_row_t        fage_q, fage_w;
  ftag_row_t        ftag_q, ftag_w;
  logic             nwe, fwe;
  logic             nrd, frd;
  logic [NSW-1:0]   nrd_addr, nrow_r;
  logic [FSW-1:0]   frd_addr, frow_r;

  always_comb begin
    nrd      = 1'b0;
    frd      = 1'b0;
    nrd_addr = nset_of(addr_r, bob_r);
    frd_addr = fset_of(addr_r, bob_r);
    case (cmd.rd_src)
      tllc_pkg::RD_MAIN: begin
        nrd = 1'b1;
        frd = 1'b1;
      end
      tllc_pkg::RD_NFILL: nrd = 1'b1;
      tllc_pkg::RD_INV: begin
        nrd      = 1'b1;
        nrd_addr = nset_of(eaddr_r, bob_r);
      end
      tllc_pkg::RD_TOUCH: begin
        frd      = 1'b1;
        frd_addr = fset_of(eaddr_r, bob_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if (clr_cnt_r < CLR_W'(NSETS)) begin
        nval_mem[clr_cnt_r[NSW-1:0]] <= '0;
        ndty_mem[clr_cnt_r[NSW-1:0]] <= '0;
        nage_mem[clr_cnt_r[NSW-1:0]] <= nage_init;
      end
      if (clr_cnt_r < CLR_W'(FSETS)) begin
        fval_mem[clr_cnt_r[FSW-1:0]] <= '0;
        fage_mem[clr_cnt_r[FSW-1:0]] <= fage_init;
      end
    end else begin
      if (nwe) begin
        nval_mem[nrow_r] <= nval_w;
        ndty_mem[nrow_r] <= ndty_w;
        nage_mem[nrow_r] <= nage_w;
        ntag_mem[nrow_r] <= ntag_w;
      end
      if (fwe) begin
        fval_mem[frow_r] <= fval_w;
        fage_mem[frow_r] <= fage_w;
        ftag_mem[frow_r] <= ftag_w;
      end
    end
    if (nrd) begin
      nval_q <= nval_mem[nrd_addr];
      ndty_q <= ndty_mem[nrd_addr];
      nage_q <= nage_mem[nrd_addr];
      ntag_q <= ntag_mem[nrd_addr];
      nrow_r <= nrd_addr;
    end
    if (frd) begin
      fval_q <= fval_mem[frd_addr];
      fage_q <= fage_mem[frd_addr];
      ftag_q <= ftag_mem[frd_addr];
      frow_r <= frd_addr;
    end
  end

  // lru touch
  function automatic nage_row_t ntouch(input nage_row_t a, input logic [NAW-1:0] way);
    nage_row_t r;
    r = a;
    for (int j = 0; j < NWAYS; j++) begin
      if (NAW'(j) == way) r[j] = NAW'(NWAYS - 1);
      else if (a[j] > a[way]) r[j] = a[j] - 1'b1;
    end
    return r;
  endfunction

  function automatic fage_row_t ftouch(input fage_row_t a, input logic [FAW-1:0] way);
    fage_row_t r;
    r = a;
    for (int j = 0; j < FWAYS; j++) begin
      if (FAW'(j) == way) r[j] = FAW'(FWAYS - 1);
      else if (a[j] > a[way]) r[j] = a[j] - 1'b1;
    end
    return r;
  endfunction

  // tag search and victim choice
  logic [31:0]    nkey, fkey;
  logic           nhit, fhit;
  logic [NAW-1:0] nway, nvict;
  logic [FAW-1:0] fway, fvict;
  logic           nfree, nzero, ffree, fzero;

  always_comb begin
    nkey = (cmd.op == tllc_pkg::OP_INV) ? (eaddr_r >> nsh) : (addr_r >> nsh);
    fkey = (cmd.op == tllc_pkg::OP_TOUCH) ? (eaddr_r >> fsh) : (addr_r >> fsh);
    nhit = 1'b0;
    nway = '0;
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (nval_q[w] && ntag_q[w] == nkey) begin
        nhit = 1'b1;
        nway = NAW'(w);
      end
    end
    fhit = 1'b0;
    fway = '0;
    for (int w = FWAYS - 1; w >= 0; w--) begin
      if (fval_q[w] && ftag_q[w] == fkey) begin
        fhit = 1'b1;
        fway = FAW'(w);
      end
    end
    nfree = 1'b0;
    nzero = 1'b0;
    nvict = '0;
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (!nval_q[w]) begin
        nfree = 1'b1;
        nvict = NAW'(w);
      end
    end
    if (!nfree) begin
      for (int w = NWAYS - 1; w >= 0; w--) begin
        if (nage_q[w] == '0) begin
          nzero = 1'b1;
          nvict = NAW'(w);
        end
      end
    end
    ffree = 1'b0;
    fzero = 1'b0;
    fvict = '0;
    for (int w = FWAYS - 1; w >= 0; w--) begin
      if (!fval_q[w]) begin
        ffree = 1'b1;
        fvict = FAW'(w);
      end
    end
    if (!ffree) begin
      for (int w = FWAYS - 1; w >= 0; w--) begin
        if (fage_q[w] == '0) begin
          fzero = 1'b1;
          fvict = FAW'(w);
        end
      end
    end
  end

  // row updates
  logic alloc;
  assign alloc = !wr_r || walloc_r;

  always_comb begin
    nwe       = 1'b0;
    fwe       = 1'b0;
    nval_w    = nval_q;
    ndty_w    = ndty_q;
    nage_w    = nage_q;
    ntag_w    = ntag_q;
    fval_w    = fval_q;
    fage_w    = fage_q;
    ftag_w    = ftag_q;
    eaddr_ld  = 1'b0;
    eaddr_nxt = (ftag_q[fvict] << fsh) | (32'(frow_r) << bob_r);
    case (cmd.op)
      tllc_pkg::OP_LOOKUP: begin
        if (nhit) begin
          nwe    = 1'b1;
          nage_w = ntouch(nage_q, nway);
          if (wr_r) ndty_w[nway] = 1'b1;
        end else if (fhit) begin
          fwe    = 1'b1;
          fage_w = ftouch(fage_q, fway);
        end else if (alloc) begin
          fwe           = 1'b1;
          eaddr_ld      = 1'b1;
          fval_w[fvict] = 1'b1;
          ftag_w[fvict] = fkey;
          fage_w        = ftouch(fage_q, fvict);
        end
      end
      tllc_pkg::OP_INV: begin
        if (nhit) begin
          nwe          = 1'b1;
          nval_w[nway] = 1'b0;
          ndty_w[nway] = 1'b0;
        end
      end
      tllc_pkg::OP_NFILL: begin
        nwe           = 1'b1;
        eaddr_ld      = 1'b1;
        eaddr_nxt     = (ntag_q[nvict] << nsh) | (32'(nrow_r) << bob_r);
        nval_w[nvict] = 1'b1;
        ndty_w[nvict] = wr_r;
        ntag_w[nvict] = nkey;
        nage_w        = ntouch(nage_q, nvict);
      end
      tllc_pkg::OP_TOUCH: begin
        if (fhit) begin
          fwe    = 1'b1;
          fage_w = ftouch(fage_q, fway);
        end
      end
      default: ;
    endcase
  end

  // result
  logic [1:0]                 res_level_r;
  logic [tllc_pkg::CYC_W-1:0] res_cyc_r;

  always_ff @(posedge clk) begin
    if (cmd.op == tllc_pkg::OP_LOOKUP) begin
      if (nhit) begin
        res_level_r <= tllc_pkg::LEVEL_L1;
        res_cyc_r   <= tllc_pkg::CYC_W'(l1_lat_r);
      end else if (fhit) begin
        res_level_r <= tllc_pkg::LEVEL_L2;
        res_cyc_r   <= tllc_pkg::CYC_W'(l1_lat_r) + tllc_pkg::CYC_W'(l2_lat_r);
      end else begin
        res_level_r <= tllc_pkg::LEVEL_MEM;
        res_cyc_r   <= tllc_pkg::CYC_W'(l1_lat_r) + tllc_pkg::CYC_W'(l2_lat_r)
                       + tllc_pkg::CYC_W'(mem_lat_r);
      end
    end
    if (cmd.out_load) begin
      out_hit_level     <= res_level_r;
      out_access_cycles <= res_cyc_r;
    end
  end

  // status
  assign status.clr_done = (clr_cnt_r == CLR_W'(CLR_ROWS));
  assign status.near_hit = nhit;
  assign status.far_hit  = fhit;
  assign status.far_ev   = fval_q[fvict] && (ffree || fzero || !ffree);
  assign status.near_evd = nval_q[nvict] && ndty_q[nvict] && (nfree || nzero || !nfree);
  assign status.is_write = wr_r;
  assign status.walloc   = walloc_r;

endmodule

### rtl/core/tllc_ctrl.sv
// sequencer of the two-level lru cache model: handshakes and access steps
// depends on tllc_pkg
`timescale 1ns / 1ps
module tllc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tllc_pkg::status_t status,
  output tllc_pkg::cmd_t    cmd
);

  tllc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             alloc;

  assign alloc = !status.is_write || status.walloc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tllc_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tllc_pkg::ST_CLEAR: if (status.clr_done) state_nxt = tllc_pkg::ST_IDLE;
      tllc_pkg::ST_IDLE: if (in_valid) state_nxt = tllc_pkg::ST_RD_MAIN;
      tllc_pkg::ST_RD_MAIN: state_nxt = tllc_pkg::ST_LOOKUP;
      tllc_pkg::ST_LOOKUP: begin
        if (status.near_hit || !alloc) state_nxt = tllc_pkg::ST_DONE;
        else if (!status.far_hit && status.far_ev) state_nxt = tllc_pkg::ST_RD_INV;
        else state_nxt = tllc_pkg::ST_RD_NFILL;
      end
      tllc_pkg::ST_RD_INV: state_nxt = tllc_pkg::ST_INV;
      tllc_pkg::ST_INV: state_nxt = tllc_pkg::ST_RD_NFILL;
      tllc_pkg::ST_RD_NFILL: state_nxt = tllc_pkg::ST_NFILL;
      tllc_pkg::ST_NFILL: begin
        if (status.near_evd) state_nxt = tllc_pkg::ST_RD_TOUCH;
        else state_nxt = tllc_pkg::ST_DONE;
      end
      tllc_pkg::ST_RD_TOUCH: state_nxt = tllc_pkg::ST_TOUCH;
      tllc_pkg::ST_TOUCH: state_nxt = tllc_pkg::ST_DONE;
      tllc_pkg::ST_DONE: if (!out_valid_r || !out_stall) state_nxt = tllc_pkg::ST_IDLE;
      default: state_nxt = tllc_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.rd_src   = tllc_pkg::RD_NONE;
    cmd.op       = tllc_pkg::OP_NONE;
    in_stall     = 1'b1;
    case (state_r)
      tllc_pkg::ST_CLEAR: cmd.clr = !status.clr_done;
      tllc_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      tllc_pkg::ST_RD_MAIN: cmd.rd_src = tllc_pkg::RD_MAIN;
      tllc_pkg::ST_LOOKUP: cmd.op = tllc_pkg::OP_LOOKUP;
      tllc_pkg::ST_RD_INV: cmd.rd_src = tllc_pkg::RD_INV;
      tllc_pkg::ST_INV: cmd.op = tllc_pkg::OP_INV;
      tllc_pkg::ST_RD_NFILL: cmd.rd_src = tllc_pkg::RD_NFILL;
      tllc_pkg::ST_NFILL: cmd.op = tllc_pkg::OP_NFILL;
      tllc_pkg::ST_RD_TOUCH: cmd.rd_src = tllc_pkg::RD_TOUCH;
      tllc_pkg::ST_TOUCH: cmd.op = tllc_pkg::OP_TOUCH;
      tllc_pkg::ST_DONE: cmd.out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/two_level_lru_cache_model.sv
// each item is read, looked up and its result loaded; a near fill, and the
// invalidate and touch that may go with it, each add a read step and a write step
// items are taken one at a time; a result waiting to load holds off the next item
// after reset a clearing pass over max(near sets, far sets) rows runs before the
// first item is taken; configuration writes are taken during it
`timescale 1ns / 1ps
`include "two_level_lru_cache_model_defines.svh"
module two_level_lru_cache_model #(
  parameter int NEAR_SETS_LOG2 = 6,
  parameter int NEAR_WAYS_LOG2 = 2,
  parameter int FAR_SETS_LOG2  = 8,
  parameter int FAR_WAYS_LOG2  = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tllc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tllc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [31:0]                     in_byte_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_hit_level,
  output logic [tllc_pkg::CYC_W-1:0]      out_access_cycles
);

  tllc_pkg::cmd_t    cmd;
  tllc_pkg::status_t status;

  tllc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tllc_dp #(
    .NEAR_SETS_LOG2 (NEAR_SETS_LOG2),
    .NEAR_WAYS_LOG2 (NEAR_WAYS_LOG2),
    .FAR_SETS_LOG2  (FAR_SETS_LOG2),
    .FAR_WAYS_LOG2  (FAR_WAYS_LOG2)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_action),
    .in_byte_address   (in_byte_address),
    .cmd               (cmd),
    .status            (status),
    .out_hit_level     (out_hit_level),
    .out_access_cycles (out_access_cycles)
  );

  `TLLC_ASSERT_IMP(a_no_accept_in_clear, !status.clr_done, in_stall)
  `TLLC_ASSERT_IMP(a_level_legal, out_valid, out_hit_level != 2'd3)
  `TLLC_ASSERT_NXT(a_accept_starts_read, cmd.accept, cmd.rd_src == tllc_pkg::RD_MAIN)

endmodule
